[src/paged_memory_with_permissions_defines.svh]
// Assertion macros shared by the checker of the paged memory block.
`ifndef PAGED_MEMORY_WITH_PERMISSIONS_DEFINES_SVH
`define PAGED_MEMORY_WITH_PERMISSIONS_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define PMP_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("pmp assertion failed");

// Next-cycle implication, sampled on clk_i and held off during reset.
`define PMP_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pmp assertion failed");

`endif

[src/pmp_pkg.sv]
// Shared types and constants of the paged memory block.
`timescale 1ns / 1ps
`default_nettype none
package pmp_pkg;

  localparam int DEF_PAGE_OFFSET_BITS = 12;
  localparam int DEF_VIRT_PAGE_BITS   = 8;
  localparam int DEF_FRAME_COUNT      = 16;

  // Width of page-number arithmetic: covers address plus length.
  localparam int PW = 23;

  typedef enum logic [2:0] {
    OP_MAP         = 3'd0,
    OP_MAP_BACKING = 3'd1,
    OP_UNMAP       = 3'd2,
    OP_REPROTECT   = 3'd3,
    OP_READ        = 3'd4,
    OP_WRITE       = 3'd5,
    OP_CHECK_RANGE = 3'd6,
    OP_GET_PERMS   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_BAD_ARG   = 3'd1,
    STS_COLLISION = 3'd2,
    STS_FAULT     = 3'd3,
    STS_NO_FRAMES = 3'd4
  } status_e;

  typedef struct packed {
    logic [63:0] write_data;
    logic [3:0]  backing_frame;
    logic [2:0]  perm;
    logic [20:0] length;
    logic [19:0] address;
    op_e         operation;
  } req_t;

  typedef struct packed {
    logic        perm_valid;
    logic [2:0]  perm_out;
    logic [63:0] read_data;
    status_e     status;
  } res_t;

endpackage
`default_nettype wire

[src/pmp_ram.sv]
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module pmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[src/pmp_ctrl.sv]
// Operation sequencer: page valid bits, allocator and memory access steps.
`timescale 1ns / 1ps
`default_nettype none
module pmp_ctrl
  import pmp_pkg::*;
#(
  parameter int PAGE_OFFSET_BITS = DEF_PAGE_OFFSET_BITS,
  parameter int VIRT_PAGE_BITS   = DEF_VIRT_PAGE_BITS,
  parameter int FRAME_COUNT      = DEF_FRAME_COUNT,
  localparam int FB     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
  localparam int PTW    = 3 + FB,
  localparam int SDEPTH = FRAME_COUNT << PAGE_OFFSET_BITS,
  localparam int SAW    = $clog2(SDEPTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      req_valid_i,
  input  wire req_t                      req_i,
  output logic                           req_ready_o,
  output res_t                           res_o,
  output logic                           res_valid_o,
  input  wire logic                      res_ready_i,
  output logic                           pt_we_o,
  output logic      [VIRT_PAGE_BITS-1:0] pt_addr_o,
  output logic      [PTW-1:0]            pt_wdata_o,
  input  wire logic [PTW-1:0]            pt_rdata_i,
  output logic                           st_we_o,
  output logic      [SAW-1:0]            st_addr_o,
  output logic      [7:0]                st_wdata_o,
  input  wire logic [7:0]                st_rdata_i
);

  localparam int NFW = $clog2(FRAME_COUNT + 1);
  localparam int ZW  = SAW + 1;
  localparam int POB = PAGE_OFFSET_BITS;
  localparam int VPB = VIRT_PAGE_BITS;
  localparam logic [PW-1:0] VPAGES = PW'(1) << VPB;
  localparam logic [PW-1:0] FC_P   = PW'(FRAME_COUNT);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EXEC, S_COLL, S_ZERO, S_MAPW, S_UNMAP, S_RPRD, S_RPWR,
    S_ACPT, S_ACCK, S_ACRD, S_CHKR, S_GPRD, S_DONE
  } state_e;

  state_e                 state_q;
  logic [(1<<VPB)-1:0]    valid_q;
  op_e                    op_q;
  logic [19:0]            addr_q;
  logic [20:0]            len_q;
  logic [2:0]             perm_q;
  logic [3:0]             bframe_q;
  logic [63:0]            wdata_q;
  logic [PW-1:0]          pg_q, end_q, va_q;
  logic [FB-1:0]          fr_q;
  logic [NFW-1:0]         nf_q;
  logic [ZW-1:0]          zc_q, ze_q;
  logic [2:0]             bi_q;
  logic [63:0]            rd_q;
  status_e                status_q;
  logic [2:0]             pout_q;
  logic                   pv_q;

  logic [PW-1:0] first, count, fc, last_pg, va_pg;
  logic          misal, cur_valid, pg_last, need_ok, byte_last;
  logic [2:0]    pt_perm;
  logic [FB-1:0] pt_frame;

  assign first     = PW'(addr_q >> POB);
  assign count     = PW'(len_q >> POB);
  assign fc        = first + count;
  assign last_pg   = (PW'(addr_q) + PW'(len_q) - PW'(1)) >> POB;
  assign va_pg     = va_q >> POB;
  assign misal     = (len_q == '0) || (addr_q[POB-1:0] != '0) || (len_q[POB-1:0] != '0);
  assign cur_valid = valid_q[pg_q[VPB-1:0]];
  assign pg_last   = (pg_q + PW'(1)) == end_q;
  assign pt_perm   = pt_rdata_i[FB +: 3];
  assign pt_frame  = pt_rdata_i[FB-1:0];
  assign need_ok   = (op_q == OP_READ) ? pt_perm[0] : pt_perm[1];
  assign byte_last = ({1'b0, bi_q} + 4'd1) == len_q[3:0];

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o = '{perm_valid: pv_q, perm_out: pout_q, read_data: rd_q, status: status_q};

  always_comb begin
    pt_we_o    = 1'b0;
    pt_addr_o  = pg_q[VPB-1:0];
    pt_wdata_o = {perm_q, fr_q};
    st_we_o    = 1'b0;
    st_addr_o  = zc_q[SAW-1:0];
    st_wdata_o = 8'd0;
    case (state_q)
      S_EXEC: pt_addr_o = first[VPB-1:0];
      S_ACPT: pt_addr_o = va_pg[VPB-1:0];
      S_MAPW: pt_we_o = 1'b1;
      S_RPWR: begin
        pt_we_o    = 1'b1;
        pt_wdata_o = {perm_q, pt_frame};
      end
      S_CLR, S_ZERO: st_we_o = 1'b1;
      S_ACCK: begin
        st_addr_o  = SAW'({pt_frame, va_q[POB-1:0]});
        st_we_o    = need_ok && (op_q == OP_WRITE);
        st_wdata_o = wdata_q[{bi_q, 3'b000} +: 8];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      valid_q  <= '0;
      nf_q     <= '0;
      zc_q     <= '0;
      ze_q     <= ZW'(SDEPTH);
      op_q     <= OP_MAP;
      addr_q   <= '0;
      len_q    <= '0;
      perm_q   <= '0;
      bframe_q <= '0;
      wdata_q  <= '0;
      pg_q     <= '0;
      end_q    <= '0;
      va_q     <= '0;
      fr_q     <= '0;
      bi_q     <= '0;
      rd_q     <= '0;
      status_q <= STS_OK;
      pout_q   <= '0;
      pv_q     <= 1'b0;
    end else begin
      case (state_q)
        S_CLR: begin
          if (zc_q + ZW'(1) == ze_q) begin
            state_q <= S_IDLE;
          end else begin
            zc_q <= zc_q + ZW'(1);
          end
        end
        S_IDLE: begin
          if (req_valid_i) begin
            op_q     <= req_i.operation;
            addr_q   <= req_i.address;
            len_q    <= req_i.length;
            perm_q   <= req_i.perm;
            bframe_q <= req_i.backing_frame;
            wdata_q  <= req_i.write_data;
            state_q  <= S_EXEC;
          end
        end
        S_EXEC: begin
          rd_q     <= '0;
          pout_q   <= '0;
          pv_q     <= 1'b0;
          status_q <= STS_OK;
          case (op_q)
            OP_MAP, OP_MAP_BACKING: begin
              if (misal || fc > VPAGES ||
                  (op_q == OP_MAP_BACKING && PW'(bframe_q) + count > FC_P)) begin
                status_q <= STS_BAD_ARG;
                state_q  <= S_DONE;
              end else begin
                pg_q    <= first;
                end_q   <= fc;
                state_q <= S_COLL;
              end
            end
            OP_UNMAP, OP_REPROTECT: begin
              if (misal) begin
                status_q <= STS_BAD_ARG;
                state_q  <= S_DONE;
              end else if (first >= VPAGES) begin
                state_q <= S_DONE;
              end else begin
                pg_q    <= first;
                end_q   <= (fc > VPAGES) ? VPAGES : fc;
                state_q <= (op_q == OP_UNMAP) ? S_UNMAP : S_RPRD;
              end
            end
            OP_READ, OP_WRITE: begin
              if (len_q == '0 || len_q > 21'd8) begin
                status_q <= STS_BAD_ARG;
                state_q  <= S_DONE;
              end else begin
                va_q    <= PW'(addr_q);
                bi_q    <= '0;
                state_q <= S_ACPT;
              end
            end
            OP_CHECK_RANGE: begin
              if (len_q == '0) begin
                state_q <= S_DONE;
              end else begin
                pg_q    <= first;
                end_q   <= last_pg + PW'(1);
                state_q <= S_CHKR;
              end
            end
            default: begin
              if (first < VPAGES && valid_q[first[VPB-1:0]]) begin
                state_q <= S_GPRD;
              end else begin
                status_q <= STS_FAULT;
                state_q  <= S_DONE;
              end
            end
          endcase
        end
        S_COLL: begin
          if (cur_valid) begin
            status_q <= STS_COLLISION;
            state_q  <= S_DONE;
          end else if (!pg_last) begin
            pg_q <= pg_q + PW'(1);
          end else if (op_q == OP_MAP) begin
            if (PW'(nf_q) + count > FC_P) begin
              status_q <= STS_NO_FRAMES;
              state_q  <= S_DONE;
            end else begin
              zc_q    <= ZW'(nf_q) << POB;
              ze_q    <= (ZW'(nf_q) + ZW'(count)) << POB;
              fr_q    <= FB'(nf_q);
              nf_q    <= nf_q + NFW'(count);
              state_q <= S_ZERO;
            end
          end else begin
            fr_q    <= FB'(bframe_q);
            pg_q    <= first;
            state_q <= S_MAPW;
          end
        end
        S_ZERO: begin
          if (zc_q + ZW'(1) == ze_q) begin
            pg_q    <= first;
            state_q <= S_MAPW;
          end else begin
            zc_q <= zc_q + ZW'(1);
          end
        end
        S_MAPW: begin
          valid_q[pg_q[VPB-1:0]] <= 1'b1;
          fr_q <= fr_q + FB'(1);
          if (pg_last) begin
            state_q <= S_DONE;
          end else begin
            pg_q <= pg_q + PW'(1);
          end
        end
        S_UNMAP: begin
          valid_q[pg_q[VPB-1:0]] <= 1'b0;
          if (pg_last) begin
            state_q <= S_DONE;
          end else begin
            pg_q <= pg_q + PW'(1);
          end
        end
        S_RPRD: begin
          if (cur_valid) begin
            state_q <= S_RPWR;
          end else if (pg_last) begin
            state_q <= S_DONE;
          end else begin
            pg_q <= pg_q + PW'(1);
          end
        end
        S_RPWR: begin
          if (pg_last) begin
            state_q <= S_DONE;
          end else begin
            pg_q    <= pg_q + PW'(1);
            state_q <= S_RPRD;
          end
        end
        S_ACPT: begin
          if (va_pg >= VPAGES || !valid_q[va_pg[VPB-1:0]]) begin
            status_q <= STS_FAULT;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_ACCK;
          end
        end
        S_ACCK: begin
          if (!need_ok) begin
            status_q <= STS_FAULT;
            state_q  <= S_DONE;
          end else if (op_q == OP_READ) begin
            state_q <= S_ACRD;
          end else if (byte_last) begin
            state_q <= S_DONE;
          end else begin
            bi_q    <= bi_q + 3'd1;
            va_q    <= va_q + PW'(1);
            state_q <= S_ACPT;
          end
        end
        S_ACRD: begin
          rd_q[{bi_q, 3'b000} +: 8] <= st_rdata_i;
          if (byte_last) begin
            state_q <= S_DONE;
          end else begin
            bi_q    <= bi_q + 3'd1;
            va_q    <= va_q + PW'(1);
            state_q <= S_ACPT;
          end
        end
        S_CHKR: begin
          if (pg_q >= VPAGES || !cur_valid) begin
            status_q <= STS_FAULT;
            state_q  <= S_DONE;
          end else if (pg_last) begin
            state_q <= S_DONE;
          end else begin
            pg_q <= pg_q + PW'(1);
          end
        end
        S_GPRD: begin
          pout_q  <= pt_perm;
          pv_q    <= 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/pmp_obuf.sv]
// Output register that holds one result word for the master side.
`timescale 1ns / 1ps
`default_nettype none
module pmp_obuf
  import pmp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire res_t res_i,
  input  wire logic res_valid_i,
  output logic      res_ready_o,
  output res_t      out_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i
);

  logic valid_q;
  res_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule
`default_nettype wire

[src/paged_memory_with_permissions.sv]
// Top level of the paged memory block with per-page permissions.
//
// One request word on the slave stream yields exactly one result word on
// the master stream. The operation code rides in s_axis_tuser; the
// remaining request fields, and all result fields, are packed in tdata.
// After reset the frame store is swept to zero, one byte per cycle, over
// all FRAME_COUNT * 2**PAGE_OFFSET_BITS bytes (65536 by default); no
// request word is taken until the sweep is done.
// The sequencer works on one request at a time over the page-table RAM and
// the byte-wide frame-store RAM, each with a registered read. Rejected
// arguments go straight to the done step; get_permissions reads the page
// table once; read and write check each byte's page, then its permission,
// and a read then fetches the byte; check_range and unmap step through the
// pages one by one; reprotect reads each page and rewrites the mapped ones;
// map scans the pages for collisions, then zeroes the new frames byte by
// byte (map only) and writes each page's entry. The block returns to its
// idle step before the next request word is taken.
// A result waits in an output register; while the receiver stalls the
// block still accepts and runs the next request, and then holds in its
// done step until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module paged_memory_with_permissions
  import pmp_pkg::*;
#(
  parameter int PAGE_OFFSET_BITS = DEF_PAGE_OFFSET_BITS,
  parameter int VIRT_PAGE_BITS   = DEF_VIRT_PAGE_BITS,
  parameter int FRAME_COUNT      = DEF_FRAME_COUNT
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // address, length, perm, backing_frame, write_data
  input  wire logic [111:0] s_axis_tdata,
  // operation
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status, read_data, perm_out, perm_valid, one zero pad bit
  output logic      [71:0]  m_axis_tdata
);

  localparam int FB     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int PTW    = 3 + FB;
  localparam int SDEPTH = FRAME_COUNT << PAGE_OFFSET_BITS;
  localparam int SAW    = $clog2(SDEPTH);

  req_t                      req;
  res_t                      res, out;
  logic                      res_valid, res_ready;
  logic                      pt_we, st_we;
  logic [VIRT_PAGE_BITS-1:0] pt_addr;
  logic [PTW-1:0]            pt_wdata, pt_rdata;
  logic [SAW-1:0]            st_addr;
  logic [7:0]                st_wdata, st_rdata;

  // Request fields in the order of tdata, operation from tuser.
  assign req = '{
    write_data:    s_axis_tdata[111:48],
    backing_frame: s_axis_tdata[47:44],
    perm:          s_axis_tdata[43:41],
    length:        s_axis_tdata[40:20],
    address:       s_axis_tdata[19:0],
    operation:     op_e'(s_axis_tuser)
  };

  pmp_ctrl #(
    .PAGE_OFFSET_BITS(PAGE_OFFSET_BITS),
    .VIRT_PAGE_BITS  (VIRT_PAGE_BITS),
    .FRAME_COUNT     (FRAME_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_i      (req),
    .req_ready_o(s_axis_tready),
    .res_o      (res),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .pt_we_o    (pt_we),
    .pt_addr_o  (pt_addr),
    .pt_wdata_o (pt_wdata),
    .pt_rdata_i (pt_rdata),
    .st_we_o    (st_we),
    .st_addr_o  (st_addr),
    .st_wdata_o (st_wdata),
    .st_rdata_i (st_rdata)
  );

  // Page table: permissions and frame index per virtual page.
  pmp_ram #(
    .WIDTH(PTW),
    .DEPTH(1 << VIRT_PAGE_BITS)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (pt_we),
    .addr_i (pt_addr),
    .wdata_i(pt_wdata),
    .rdata_o(pt_rdata)
  );

  // Frame store, one byte per word.
  pmp_ram #(
    .WIDTH(8),
    .DEPTH(SDEPTH)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .addr_i (st_addr),
    .wdata_i(st_wdata),
    .rdata_o(st_rdata)
  );

  pmp_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .res_valid_i(res_valid),
    .res_ready_o(res_ready),
    .out_o      (out),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, out};

endmodule
`default_nettype wire

[src/pmp_checker.sv]
// Port-level checker for the paged memory block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "paged_memory_with_permissions_defines.svh"
module pmp_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [111:0] s_axis_tdata,
  input wire logic [2:0]   s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [71:0]  m_axis_tdata
);

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready && (s_axis_tdata[0] | ~s_axis_tdata[0])
                  && (s_axis_tuser[0] | ~s_axis_tuser[0]);

  // A stalled result word stays put.
  `PMP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // Valid permissions come only with an ok status.
  `PMP_ASSERT_IMP(a_perm_ok, m_axis_tvalid && m_axis_tdata[70], m_axis_tdata[2:0] == 3'd0)
  // Without valid permissions the permission field reads zero.
  `PMP_ASSERT_IMP(a_perm_zero, m_axis_tvalid && !m_axis_tdata[70], m_axis_tdata[69:67] == 3'd0)
  // Status stays within the defined codes.
  `PMP_ASSERT_IMP(a_status_code, m_axis_tvalid, m_axis_tdata[2:0] <= 3'd4)
  // The block is never ready in the cycle after it takes a request.
  `PMP_ASSERT_NXT(a_one_at_a_time, s_fire, !s_axis_tready)

endmodule

bind paged_memory_with_permissions pmp_checker u_pmp_checker (.*);
`default_nettype wire

[test/tb_paged_memory_with_permissions.sv]
// Testbench for the paged memory block: stream driver, result checker and predictor.
`timescale 1ns / 1ps
module tb_paged_memory_with_permissions;
  import pmp_pkg::*;

  localparam int PG_BITS  = DEF_PAGE_OFFSET_BITS;
  localparam int PG_SIZE  = 1 << PG_BITS;
  localparam int NPAGES   = 1 << DEF_VIRT_PAGE_BITS;
  localparam int NFRAMES  = DEF_FRAME_COUNT;
  localparam int N_RANDOM = 1350;

  typedef struct {
    req_t word;
    bit   drain;  // hold this word back until every result is in
  } stim_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;

  paged_memory_with_permissions u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the page table, the frame store and the frame allocator.
  bit         pt_valid [NPAGES];
  logic [2:0] pt_perm  [NPAGES];
  int         pt_frame [NPAGES];
  logic [7:0] store    [NFRAMES * PG_SIZE];
  int         alloc_next;

  stim_t pend_q[$];
  res_t  result_q[$];
  req_t  shown;
  int    errors, n_sent, n_checked, n_ok, n_fault, n_other, n_pushed;
  int    src_gap, sink_stall;
  bit    calm;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH result %0d %s: got %h expected %h", n_checked, what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Applies one request to the shadow state and returns its result word.
  function automatic res_t apply_request(req_t q);
    res_t        r;
    longint      a, l, first, cnt, i, pg, va, base;
    logic [2:0]  need;
    bit          stop, is_map;
    r = '0;
    r.status = STS_OK;
    a = q.address;
    l = q.length;
    is_map = (q.operation == OP_MAP);
    case (q.operation)
      OP_MAP, OP_MAP_BACKING: begin
        if (l == 0 || a % PG_SIZE != 0 || l % PG_SIZE != 0) begin
          r.status = STS_BAD_ARG;
        end else begin
          first = a / PG_SIZE;
          cnt = l / PG_SIZE;
          stop = 1'b0;
          for (i = first; i < first + cnt && i < NPAGES; i++) if (pt_valid[i]) stop = 1'b1;
          if (first + cnt > NPAGES) r.status = STS_BAD_ARG;
          else if (!is_map && q.backing_frame + cnt > NFRAMES) r.status = STS_BAD_ARG;
          else if (stop) r.status = STS_COLLISION;
          else if (is_map && alloc_next + cnt > NFRAMES) r.status = STS_NO_FRAMES;
          else begin
            base = is_map ? alloc_next : q.backing_frame;
            if (is_map) begin
              for (i = base * PG_SIZE; i < (base + cnt) * PG_SIZE; i++) store[i] = 8'h00;
              alloc_next += int'(cnt);
            end
            for (i = 0; i < cnt; i++) begin
              pt_valid[first + i] = 1'b1;
              pt_perm[first + i]  = q.perm;
              pt_frame[first + i] = int'(base + i);
            end
          end
        end
      end
      OP_UNMAP, OP_REPROTECT: begin
        if (l == 0 || a % PG_SIZE != 0 || l % PG_SIZE != 0) begin
          r.status = STS_BAD_ARG;
        end else begin
          first = a / PG_SIZE;
          // Pages past the end of the virtual space are quietly ignored.
          for (i = first; i < first + l / PG_SIZE && i < NPAGES; i++) begin
            if (q.operation == OP_UNMAP) begin
              pt_valid[i] = 1'b0;
              pt_perm[i]  = '0;
              pt_frame[i] = 0;
            end else if (pt_valid[i]) begin
              pt_perm[i] = q.perm;
            end
          end
        end
      end
      OP_READ, OP_WRITE: begin
        need = (q.operation == OP_READ) ? 3'b001 : 3'b010;
        if (l == 0 || l > 8) begin
          r.status = STS_BAD_ARG;
        end else begin
          stop = 1'b0;
          // Bytes ahead of a faulting byte are still moved.
          for (i = 0; i < l && !stop; i++) begin
            va = a + i;
            pg = va >> PG_BITS;
            if (pg >= NPAGES || !pt_valid[pg] || (pt_perm[pg] & need) != need) begin
              r.status = STS_FAULT;
              stop = 1'b1;
            end else begin
              base = longint'(pt_frame[pg]) * PG_SIZE + va % PG_SIZE;
              if (q.operation == OP_READ) r.read_data[8*i +: 8] = store[base];
              else store[base] = q.write_data[8*i +: 8];
            end
          end
        end
      end
      OP_CHECK_RANGE: begin
        if (l != 0) begin
          for (pg = a >> PG_BITS; pg <= (a + l - 1) >> PG_BITS; pg++) begin
            if (pg >= NPAGES || !pt_valid[pg]) begin
              r.status = STS_FAULT;
              break;
            end
          end
        end
      end
      default: begin
        pg = a >> PG_BITS;
        if (pg < NPAGES && pt_valid[pg]) begin
          r.perm_out = pt_perm[pg];
          r.perm_valid = 1'b1;
        end else begin
          r.status = STS_FAULT;
        end
      end
    endcase
    return r;
  endfunction

  function automatic req_t make_req(op_e op, int addr, int len, logic [2:0] perm,
                                    logic [3:0] bframe, logic [63:0] wdata);
    req_t q;
    q.operation = op;
    q.address = addr[19:0];
    q.length = len[20:0];
    q.perm = perm;
    q.backing_frame = bframe;
    q.write_data = wdata;
    return q;
  endfunction

  // Prefers a page that is mapped right now so accesses get past translation.
  function automatic int likely_page();
    int p;
    for (int k = 0; k < 8; k++) begin
      p = $urandom_range(0, NPAGES - 1);
      if (pt_valid[p]) return p;
    end
    return p;
  endfunction

  function automatic req_t random_req();
    req_t       q;
    int         sel, pg, off, len;
    logic [63:0] wd;
    sel = $urandom_range(0, 99);
    wd = {$urandom, $urandom};
    q = make_req(OP_READ, 0, 0, 3'($urandom), 4'($urandom), wd);
    if (sel < 14) begin
      pg = $urandom_range(0, NPAGES - 1);
      q.operation = ($urandom_range(0, 2) == 0) ? OP_MAP : OP_MAP_BACKING;
      q.address = 20'(pg * PG_SIZE);
      q.length = 21'($urandom_range(1, 4) * PG_SIZE);
      if ($urandom_range(0, 4) == 0) q.perm = 3'b111;
    end else if (sel < 20) begin
      q.operation = OP_UNMAP;
      q.address = 20'(likely_page() * PG_SIZE);
      q.length = 21'($urandom_range(1, 3) * PG_SIZE);
      // Now and then wipe the whole table so the maps keep finding free pages.
      if ($urandom_range(0, 5) == 0) begin
        q.address = '0;
        q.length = 21'(NPAGES * PG_SIZE);
      end
    end else if (sel < 27) begin
      q.operation = OP_REPROTECT;
      q.address = 20'(likely_page() * PG_SIZE);
      q.length = 21'($urandom_range(1, 3) * PG_SIZE);
      if ($urandom_range(0, 1) == 0) q.perm = 3'b011;
    end else if (sel < 75) begin
      q.operation = (sel < 51) ? OP_READ : OP_WRITE;
      pg = likely_page();
      off = ($urandom_range(0, 3) == 0) ? $urandom_range(PG_SIZE - 8, PG_SIZE - 1)
                                        : $urandom_range(0, PG_SIZE - 1);
      q.address = 20'(pg * PG_SIZE + off);
      len = $urandom_range(1, 8);
      if ($urandom_range(0, 29) == 0) len = $urandom_range(0, 20);
      q.length = 21'(len);
    end else if (sel < 85) begin
      q.operation = OP_CHECK_RANGE;
      q.address = 20'(likely_page() * PG_SIZE + $urandom_range(0, PG_SIZE - 1));
      q.length = 21'($urandom_range(0, 3 * PG_SIZE));
    end else if (sel < 95) begin
      q.operation = OP_GET_PERMS;
      q.address = 20'(likely_page() * PG_SIZE + $urandom_range(0, PG_SIZE - 1));
    end else begin
      // Raw noise over every field, including the top length bit.
      q.operation = op_e'($urandom_range(0, 7));
      q.address = 20'($urandom);
      q.length = 21'($urandom);
    end
    return q;
  endfunction

  task automatic push_req(req_t q, bit drain);
    stim_t s;
    s.word = q;
    s.drain = drain;
    pend_q = {pend_q, s};
    n_pushed++;
  endtask

  // Driver: presents queued words and predicts each one as it is taken.
  always @(posedge clk_i) begin : drive_requests
    logic  nv;
    stim_t s;
    res_t  pr;
    nv = s_axis_tvalid;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pr = apply_request(shown);
        result_q = {result_q, pr};
        n_sent++;
        nv = 1'b0;
        src_gap = pick_gap();
        if ($urandom_range(0, 199) == 0) calm = ~calm;
      end
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pend_q.size() > 0 && !(pend_q[0].drain && result_q.size() > 0)) begin
          s = pend_q.pop_front();
          shown = s.word;
          nv = 1'b1;
          s_axis_tdata <= {s.word.write_data, s.word.backing_frame, s.word.perm,
                           s.word.length, s.word.address};
          s_axis_tuser <= s.word.operation;
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // Monitor: checks each taken result word against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    res_t want;
    logic nr;
    nr = m_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result word", 64'(m_axis_tdata), 64'd0);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata[2:0] != want.status)
            report_mismatch("status", m_axis_tdata[2:0], want.status);
          if (m_axis_tdata[66:3] != want.read_data)
            report_mismatch("read_data", m_axis_tdata[66:3], want.read_data);
          if (m_axis_tdata[69:67] != want.perm_out)
            report_mismatch("perm_out", m_axis_tdata[69:67], want.perm_out);
          if (m_axis_tdata[70] != want.perm_valid)
            report_mismatch("perm_valid", m_axis_tdata[70], want.perm_valid);
          if (want.status == STS_OK) n_ok++;
          else if (want.status == STS_FAULT) n_fault++;
          else n_other++;
        end
        n_checked++;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        nr = 1'b0;
      end else begin
        sink_stall = pick_gap();
        nr = (sink_stall == 0);
      end
    end
    m_axis_tready <= nr;
  end

  initial begin
    int j;
    for (int p = 0; p < NPAGES; p++) begin
      pt_valid[p] = 1'b0;
      pt_perm[p] = '0;
      pt_frame[p] = 0;
    end
    for (int b = 0; b < NFRAMES * PG_SIZE; b++) store[b] = 8'h00;
    alloc_next = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: every operation, every status and the boundary cases.
    push_req(make_req(OP_MAP, 0, PG_SIZE, 3'b111, 0, 0), 0);
    push_req(make_req(OP_WRITE, 0, 8, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF), 0);
    push_req(make_req(OP_READ, 0, 8, 0, 0, 0), 0);
    push_req(make_req(OP_WRITE, PG_SIZE - 3, 6, 0, 0, 64'h1122_3344_5566_7788), 0);
    push_req(make_req(OP_READ, PG_SIZE - 4, 8, 0, 0, 0), 0);
    push_req(make_req(OP_MAP, 0, 0, 0, 0, 0), 0);
    push_req(make_req(OP_MAP, 5 * PG_SIZE + 4, PG_SIZE, 0, 0, 0), 0);
    push_req(make_req(OP_MAP, 5 * PG_SIZE, PG_SIZE + 1, 0, 0, 0), 0);
    push_req(make_req(OP_MAP, 0, 2 * PG_SIZE, 3'b001, 0, 0), 0);
    push_req(make_req(OP_MAP_BACKING, 254 * PG_SIZE, 2 * PG_SIZE, 3'b011, 4'd15, 0), 0);
    push_req(make_req(OP_MAP_BACKING, 255 * PG_SIZE, 2 * PG_SIZE, 3'b011, 4'd14, 0), 0);
    push_req(make_req(OP_MAP_BACKING, 254 * PG_SIZE, 2 * PG_SIZE, 3'b110, 4'd14, 0), 0);
    push_req(make_req(OP_MAP, 16 * PG_SIZE, 16 * PG_SIZE, 3'b111, 0, 0), 0);
    push_req(make_req(OP_GET_PERMS, 255 * PG_SIZE + 7, 0, 0, 0, 0), 0);
    push_req(make_req(OP_GET_PERMS, 100 * PG_SIZE, 0, 0, 0, 0), 0);
    push_req(make_req(OP_READ, 254 * PG_SIZE, 2, 0, 0, 0), 0);
    push_req(make_req(OP_REPROTECT, 0, 2 * PG_SIZE, 3'b010, 0, 0), 0);
    push_req(make_req(OP_READ, 0, 1, 0, 0, 0), 0);
    push_req(make_req(OP_WRITE, 8, 9, 0, 0, 0), 0);
    push_req(make_req(OP_READ, 8, 0, 0, 0, 0), 0);
    push_req(make_req(OP_CHECK_RANGE, 12, 0, 0, 0, 0), 0);
    push_req(make_req(OP_CHECK_RANGE, 0, PG_SIZE + 1, 0, 0, 0), 0);
    push_req(make_req(OP_CHECK_RANGE, 20'hFFFFF, 21'h100000, 0, 0, 0), 0);
    push_req(make_req(OP_UNMAP, 250 * PG_SIZE, 10 * PG_SIZE, 0, 0, 0), 0);
    push_req(make_req(OP_MAP, 0, 21'h100000, 3'b101, 0, 0), 1);

    // Random part, topped up as the driver drains, so page picks follow the table.
    j = 0;
    while (j < N_RANDOM) begin
      @(posedge clk_i);
      while (pend_q.size() < 4 && j < N_RANDOM) begin
        push_req(random_req(), (j % 300) == 150);
        j++;
      end
    end
    while (n_checked < n_pushed) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    if (result_q.size() > 0) begin
      report_mismatch("results never arrived", longint'(result_q.size()), 64'd0);
    end
    $display("Checked %0d result words for %0d requests over all eight operations:",
             n_checked, n_sent);
    $display("  %0d ok, %0d faults, %0d other rejections", n_ok, n_fault, n_other);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding", result_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/pmp_pkg.sv
src/pmp_ram.sv
src/pmp_ctrl.sv
src/pmp_obuf.sv
src/paged_memory_with_permissions.sv
src/pmp_checker.sv
test/tb_paged_memory_with_permissions.sv
